/* hdl/pwcf_pkg.sv */
// pwcf_pkg: types, constants and codes for the pulse width capture fifo
// no dependencies; used by pulse_width_capture_fifo
package pwcf_pkg;

  // width ring buffer geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int COUNT_W = 16;

  // empty read answer
  localparam logic [COUNT_W-1:0] EMPTY_VALUE = 16'hFFFF;

  // divide by three as multiply by reciprocal: floor(w * 43691 / 2^17) == w / 3 for w < 2^16
  localparam int DIV3_MUL_W = 17;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 17'h0AAAB;
  localparam int DIV3_SHIFT = 17;
  localparam int DIV3_PROD_W = COUNT_W + DIV3_MUL_W;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_POLARITY = 1'b0;
  localparam logic REG_DIVIDE = 1'b1;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_CAPTURE     = 2'd0,
    FUNC_READ_OLDEST = 2'd1,
    FUNC_READ_NEWEST = 2'd2,
    FUNC_RESTART     = 2'd3
  } func_t;

  // input item
  typedef struct packed {
    func_t              func;
    logic [COUNT_W-1:0] capture_count;
  } item_t;

  // result item
  typedef struct packed {
    logic               next_edge;
    logic [COUNT_W-1:0] read_value;
    logic               data_available;
  } result_t;

endpackage

/* hdl/pulse_width_capture_fifo.sv */
// pulse_width_capture_fifo: pulse width capture with a ring buffer of widths
// uses pwcf_pkg for types, constants and function codes
// the result of an item is registered in the output register, or in the skid register while the output is held
// one item per cycle while item_stall is low; a two-entry result buffer (output register
// plus skid register) lets an item be accepted while a result waits
// reset (synchronous, rst high): edge state, indexes, start count and
// registers cleared (divide_by_three set); the width store is not cleared
module pulse_width_capture_fifo (
  input  logic                               clk,
  input  logic                               rst,
  // item channel
  input  logic                               item_valid,
  output logic                               item_stall,
  input  pwcf_pkg::item_t                    item,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output pwcf_pkg::result_t                  result,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pwcf_pkg::ADDR_W-1:0]        paddr,
  input  logic [pwcf_pkg::DATA_W-1:0]        pwdata,
  output logic [pwcf_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  // configuration registers
  logic polarity_negative;
  logic divide_by_three;

  // capture state
  logic                             waiting_end;
  logic                             waiting_end_next;
  logic [pwcf_pkg::COUNT_W-1:0]     start_count;
  logic [pwcf_pkg::COUNT_W-1:0]     start_count_next;
  logic [pwcf_pkg::IDX_W-1:0]       read_index;
  logic [pwcf_pkg::IDX_W-1:0]       read_index_next;
  logic [pwcf_pkg::IDX_W-1:0]       write_index;
  logic [pwcf_pkg::IDX_W-1:0]       write_index_next;
  logic [pwcf_pkg::COUNT_W-1:0]     width_store [pwcf_pkg::DEPTH];

  // per-item datapath
  logic                             item_accept;
  logic                             store_write;
  logic [pwcf_pkg::COUNT_W-1:0]     width;
  logic [pwcf_pkg::IDX_W-1:0]       write_wrap;
  logic [pwcf_pkg::IDX_W-1:0]       read_wrap;
  logic [pwcf_pkg::IDX_W-1:0]       last_index;
  logic [pwcf_pkg::IDX_W-1:0]       fetch_index;
  logic [pwcf_pkg::COUNT_W-1:0]     fetch_value;
  logic [pwcf_pkg::DIV3_PROD_W-1:0] div_prod;
  logic [pwcf_pkg::COUNT_W-1:0]     scaled_value;
  logic                             buffer_nonempty;
  logic                             fetch_used;
  logic [pwcf_pkg::COUNT_W-1:0]     value;
  pwcf_pkg::result_t                result_next;

  // result buffer
  logic                             skid_valid;
  pwcf_pkg::result_t                skid;
  logic                             result_take;

  // handshakes
  assign item_stall  = skid_valid;
  assign item_accept = item_valid && !skid_valid;
  assign result_take = result_valid && !result_stall;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      pwcf_pkg::REG_POLARITY: prdata = {{(pwcf_pkg::DATA_W-1){1'b0}}, polarity_negative};
      pwcf_pkg::REG_DIVIDE:   prdata = {{(pwcf_pkg::DATA_W-1){1'b0}}, divide_by_three};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      polarity_negative <= 1'b0;
      divide_by_three   <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        pwcf_pkg::REG_POLARITY: polarity_negative <= pwdata[0];
        pwcf_pkg::REG_DIVIDE:   divide_by_three   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // ring index arithmetic
  assign write_wrap = (write_index == pwcf_pkg::IDX_W'(pwcf_pkg::DEPTH - 1)) ?
                      '0 : write_index + 1'b1;
  assign read_wrap  = (read_index == pwcf_pkg::IDX_W'(pwcf_pkg::DEPTH - 1)) ?
                      '0 : read_index + 1'b1;
  assign last_index = (write_index == '0) ?
                      pwcf_pkg::IDX_W'(pwcf_pkg::DEPTH - 1) : write_index - 1'b1;
  assign buffer_nonempty = (read_index != write_index);
  assign width = item.capture_count - start_count;

  // single store read: oldest or newest entry
  assign fetch_index = (item.func == pwcf_pkg::FUNC_READ_NEWEST) ? last_index : read_index;
  assign fetch_value = width_store[fetch_index];

  // divide by three through the reciprocal
  assign div_prod = fetch_value * pwcf_pkg::DIV3_MUL;
  assign scaled_value = divide_by_three ?
                        div_prod[pwcf_pkg::DIV3_SHIFT +: pwcf_pkg::COUNT_W] : fetch_value;

  // next state and read value for the item
  always_comb begin
    waiting_end_next = waiting_end;
    start_count_next = start_count;
    read_index_next  = read_index;
    write_index_next = write_index;
    store_write      = 1'b0;
    fetch_used       = 1'b0;
    case (item.func)
      pwcf_pkg::FUNC_CAPTURE: begin
        if (!waiting_end) begin
          waiting_end_next = 1'b1;
          start_count_next = item.capture_count;
        end else begin
          waiting_end_next = 1'b0;
          store_write      = 1'b1;
          if (write_wrap != read_index) begin
            write_index_next = write_wrap;
          end
        end
      end
      pwcf_pkg::FUNC_READ_OLDEST: begin
        if (buffer_nonempty) begin
          fetch_used      = 1'b1;
          read_index_next = read_wrap;
        end
      end
      pwcf_pkg::FUNC_READ_NEWEST: begin
        if (buffer_nonempty) begin
          fetch_used      = 1'b1;
          read_index_next = write_index;
        end
      end
      pwcf_pkg::FUNC_RESTART: begin
        waiting_end_next = 1'b0;
        read_index_next  = '0;
        write_index_next = '0;
      end
      default: ;
    endcase

    if (fetch_used) begin
      value = scaled_value;
    end else if (item.func == pwcf_pkg::FUNC_READ_OLDEST ||
                 item.func == pwcf_pkg::FUNC_READ_NEWEST) begin
      value = pwcf_pkg::EMPTY_VALUE;
    end else begin
      value = '0;
    end

    result_next.next_edge      = waiting_end_next ^ polarity_negative;
    result_next.read_value     = value;
    result_next.data_available = (read_index_next != write_index_next);
  end

  // capture state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting_end <= 1'b0;
      start_count <= '0;
      read_index  <= '0;
      write_index <= '0;
    end else if (item_accept) begin
      waiting_end <= waiting_end_next;
      start_count <= start_count_next;
      read_index  <= read_index_next;
      write_index <= write_index_next;
    end
  end

  // width store, no reset
  always_ff @(posedge clk) begin
    if (item_accept && store_write) begin
      width_store[write_index] <= width;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_take) begin
        result     <= skid;
        skid_valid <= 1'b0;
      end
    end else if (item_accept) begin
      if (!result_valid || result_take) begin
        result       <= result_next;
        result_valid <= 1'b1;
      end else begin
        skid       <= result_next;
        skid_valid <= 1'b1;
      end
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // skid entry only exists behind a full output register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("skid register holds a result while output register is empty");

  // a waiting skid entry moves forward once the output is taken
  assert property (@(posedge clk) disable iff (rst)
    skid_valid && !result_stall |=> !skid_valid)
    else $error("skid entry not drained after output taken");

  // restart clears both indexes
  assert property (@(posedge clk) disable iff (rst)
    item_accept && item.func == pwcf_pkg::FUNC_RESTART |=>
      read_index == '0 && write_index == '0)
    else $error("restart did not clear the indexes");

  // an end edge never makes a non-empty buffer look empty
  assert property (@(posedge clk) disable iff (rst)
    item_accept && item.func == pwcf_pkg::FUNC_CAPTURE && waiting_end &&
      read_index != write_index |=> read_index != write_index)
    else $error("write index overran read index on full buffer");
`endif

endmodule
